// ===== rtl/core/lrie_pkg.sv =====
// ----------------------------------------------------------------------------
// lrie_pkg
// Shared constants, mode codes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package lrie_pkg;

	localparam int COORD_WIDTH_DEF     = 20;
	localparam int ANGLE_FRAC_BITS_DEF = 12;
	localparam int CORDIC_STAGES_DEF   = 16;

	localparam int    ATAN_LEN   = 24;
	localparam longint TABLE_UNIT = 64'sd100000000000;

	typedef enum logic [1:0] {
		MODE_16     = 2'd0,
		MODE_32     = 2'd1,
		MODE_64     = 2'd2,
		MODE_UNUSED = 2'd3
	} scan_mode_t;

	typedef struct packed {
		logic [5:0] ring;
		logic       keep;
	} ring_res_t;

	// atan(2^-i) in units of 1e-11 degree
	localparam longint ATAN_TBL [ATAN_LEN] = '{
		64'sd4500000000000, 64'sd2656505117708, 64'sd1403624346793, 64'sd712501634890,
		64'sd357633437500, 64'sd178991060825, 64'sd89517371021, 64'sd44761417086,
		64'sd22381050037, 64'sd11190567707, 64'sd5595289189, 64'sd2797645262,
		64'sd1398822714, 64'sd699411368, 64'sd349705685, 64'sd174852843,
		64'sd87426421, 64'sd43713211, 64'sd21856605, 64'sd10928303,
		64'sd5464151, 64'sd2732076, 64'sd1366038, 64'sd683019
	};

	function automatic longint atan_step(int idx, int frac);
		longint scaled;
		scaled = ATAN_TBL[idx] * (longint'(1) << frac);
		return (scaled + TABLE_UNIT / 2) / TABLE_UNIT;
	endfunction

	function automatic int guard_bits(int cw);
		return (cw < 27) ? 27 - cw : 0;
	endfunction

endpackage

// ===== rtl/core/lrie_pt_if.sv =====
// ----------------------------------------------------------------------------
// lrie_pt_if
// Point channel: valid/ready with coordinates, intensity and sweep end.
// ----------------------------------------------------------------------------
interface lrie_pt_if #(
	parameter int CW = 20
);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] pos_x;
	logic signed [CW-1:0] pos_y;
	logic signed [CW-1:0] pos_z;
	logic [7:0]           echo_strength;
	logic                 cloud_end;

	modport source (output valid, pos_x, pos_y, pos_z, echo_strength, cloud_end,
		input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, echo_strength, cloud_end,
		output ready);
endinterface

// ===== rtl/core/lrie_res_if.sv =====
// ----------------------------------------------------------------------------
// lrie_res_if
// Result channel: valid/ready with the point copy, ring index and kept flag.
// ----------------------------------------------------------------------------
interface lrie_res_if #(
	parameter int CW = 20
);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] out_x;
	logic signed [CW-1:0] out_y;
	logic signed [CW-1:0] out_z;
	logic [7:0]           out_strength;
	logic [5:0]           ring_index;
	logic                 kept;
	logic                 out_cloud_end;

	modport source (output valid, out_x, out_y, out_z, out_strength, ring_index, kept,
		out_cloud_end, input ready);
	modport sink (input valid, out_x, out_y, out_z, out_strength, ring_index, kept,
		out_cloud_end, output ready);
endinterface

// ===== rtl/core/lrie_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// lrie_sqrt_cell
// One digit of a restoring square root: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module lrie_sqrt_cell #(
	parameter int RW = 27
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] rad_i,
	input  logic [RW+1:0]   rem_i,
	input  logic [RW-1:0]   root_i,
	output logic [2*RW-1:0] rad_q,
	output logic [RW+1:0]   rem_q,
	output logic [RW-1:0]   root_q
);
	logic [RW+1:0] rem2;
	logic [RW+1:0] trial;
	logic          ge;

	always_comb begin
		rem2  = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
		trial = {root_i, 2'b01};
		ge    = (rem2 >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= rad_i << 2;
			rem_q  <= ge ? rem2 - trial : rem2;
			root_q <= {root_i[RW-2:0], ge};
		end
	end
endmodule

// ===== rtl/core/lrie_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// lrie_cordic_cell
// One vectoring micro-rotation with a fixed shift and angle step.
// ----------------------------------------------------------------------------
module lrie_cordic_cell #(
	parameter int DW   = 30,
	parameter int AW   = 20,
	parameter int IDX  = 0,
	parameter int FRAC = 12
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [DW-1:0] cx_i,
	input  logic signed [DW-1:0] cy_i,
	input  logic signed [AW-1:0] ang_i,
	output logic signed [DW-1:0] cx_q,
	output logic signed [DW-1:0] cy_q,
	output logic signed [AW-1:0] ang_q
);
	import lrie_pkg::*;

	localparam logic signed [AW-1:0] STEP = AW'(atan_step(IDX, FRAC));

	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;

	assign dx = cy_i >>> IDX;
	assign dy = cx_i >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!cy_i[DW-1]) begin
				cx_q  <= cx_i + dx;
				cy_q  <= cy_i - dy;
				ang_q <= ang_i + STEP;
			end else begin
				cx_q  <= cx_i - dx;
				cy_q  <= cy_i + dy;
				ang_q <= ang_i - STEP;
			end
		end
	end
endmodule

// ===== rtl/core/lrie_ring_map.sv =====
// ----------------------------------------------------------------------------
// lrie_ring_map
// Angle word to ring index for the 16, 32 and 64 line rules, two stages.
// ----------------------------------------------------------------------------
module lrie_ring_map #(
	parameter int AW   = 20,
	parameter int FRAC = 12
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] ang,
	input  logic [1:0]           mode,
	output lrie_pkg::ring_res_t  res_s2
);
	import lrie_pkg::*;

	localparam int WW = FRAC + 18;
	localparam logic signed [WW-1:0] ONE = WW'(longint'(1) << FRAC);

	logic signed [WW-1:0] aw, n0, n1, n2, m, a100;
	logic                 keep0, keep1, br1, drop2;
	logic [3:0]           id0;
	logic [4:0]           id1;
	logic [5:0]           id2a;
	logic [11:0]          t;

	logic       keep0_s1, keep1_s1, br1_s1, drop2_s1;
	logic [3:0] id0_s1;
	logic [4:0] id1_s1;
	logic [5:0] id2a_s1;
	logic [11:0] t_s1;
	logic [1:0] mode_s1;

	logic [24:0] prod;
	logic [5:0]  id2b;
	ring_res_t   nxt;

	always_comb begin
		aw    = WW'(ang);
		a100  = WW'(aw * 100);
		n0    = WW'(aw + 16 * ONE);
		n1    = WW'(3 * aw + 92 * ONE);
		n2    = WW'(13 * ONE - 6 * aw);
		m     = WW'(-1716 * ONE - 200 * aw);
		keep0 = (n0 > -2 * ONE) && (n0 < 32 * ONE);
		id0   = n0[WW-1] ? 4'd0 : n0[FRAC+4:FRAC+1];
		keep1 = (n1 > -4 * ONE) && (n1 < 128 * ONE);
		id1   = n1[WW-1] ? 5'd0 : n1[FRAC+6:FRAC+2];
		br1   = a100 >= -883 * ONE;
		id2a  = n2[FRAC+6:FRAC+1];
		drop2 = (aw > 2 * ONE) || (a100 < -2433 * ONE);
		t     = m[FRAC+11:FRAC];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			keep0_s1 <= keep0;
			keep1_s1 <= keep1;
			br1_s1   <= br1;
			drop2_s1 <= drop2;
			id0_s1   <= id0;
			id1_s1   <= id1;
			id2a_s1  <= id2a;
			t_s1     <= t;
			mode_s1  <= mode;
		end
	end

	// divide by 100: exact below 43699
	always_comb begin
		prod = 25'(t_s1) * 25'd5243;
		id2b = 6'd32 + 6'(prod[24:19]);
		nxt  = '0;
		unique case (mode_s1)
			MODE_16: begin
				nxt.keep = keep0_s1;
				nxt.ring = keep0_s1 ? 6'(id0_s1) : 6'd0;
			end
			MODE_32: begin
				nxt.keep = keep1_s1;
				nxt.ring = keep1_s1 ? 6'(id1_s1) : 6'd0;
			end
			MODE_64: begin
				if (drop2_s1) begin
					nxt.keep = 1'b0;
				end else if (br1_s1) begin
					nxt.keep = 1'b1;
					nxt.ring = id2a_s1;
				end else begin
					nxt.keep = (id2b <= 6'd50);
					nxt.ring = (id2b <= 6'd50) ? id2b : 6'd0;
				end
			end
			default: begin
				nxt = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= nxt;
		end
	end
endmodule

// ===== rtl/core/lidar_ring_index_from_elevation_core.sv =====
// ----------------------------------------------------------------------------
// lidar_ring_index_from_elevation_core
// Elevation angle by square-root and CORDIC cell chains, then ring lookup.
//
//   channel   dir  payload
//   pt        in   pos_x/y/z, echo_strength, cloud_end
//   res       out  out_x/y/z, out_strength, ring_index, kept, out_cloud_end
//   scan_mode in   2-bit write, no read-back
//
// One beat per cycle; the chain has one sqrt cell per root bit and one CORDIC
// cell per rotation. The whole chain holds while a result waits; pt.ready is
// low then. Reset clears the valid bits and scan_mode.
// ----------------------------------------------------------------------------
module lidar_ring_index_from_elevation_core #(
	parameter int COORD_WIDTH     = lrie_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = lrie_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = lrie_pkg::CORDIC_STAGES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan_mode_we,
	input  logic [1:0] scan_mode_wdata,
	lrie_pt_if.sink    pt,
	lrie_res_if.source res
);
	import lrie_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int G   = guard_bits(CW);
	localparam int RW  = CW + G;
	localparam int SQW = 2 * RW;
	localparam int DW  = RW + 3;
	localparam int AW  = ANGLE_FRAC_BITS + 8;
	localparam int S   = CORDIC_STAGES;
	localparam int LAT = 5 + RW + S;

	logic [1:0] scan_mode_q;
	logic       en;

	logic                 vld_q [LAT];
	logic signed [CW-1:0] x_q   [LAT];
	logic signed [CW-1:0] y_q   [LAT];
	logic signed [CW-1:0] z_q   [LAT];
	logic [7:0]           str_q [LAT];
	logic                 end_q [LAT];

	logic [2*CW-1:0] sqx_s1, sqy_s1, sum_s2;

	logic [SQW-1:0] rad_c  [RW+1];
	logic [RW+1:0]  rem_c  [RW+1];
	logic [RW-1:0]  root_c [RW+1];

	logic signed [DW-1:0] cx_c  [S+1];
	logic signed [DW-1:0] cy_c  [S+1];
	logic signed [AW-1:0] ang_c [S+1];

	ring_res_t ring_s2;

	assign en       = !vld_q[LAT-1] || res.ready;
	assign pt.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode_q <= MODE_16;
		end else if (scan_mode_we) begin
			scan_mode_q <= scan_mode_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= pt.valid;
			for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]   <= pt.pos_x;
			y_q[0]   <= pt.pos_y;
			z_q[0]   <= pt.pos_z;
			str_q[0] <= pt.echo_strength;
			end_q[0] <= pt.cloud_end;
			for (int i = 1; i < LAT; i++) begin
				x_q[i]   <= x_q[i-1];
				y_q[i]   <= y_q[i-1];
				z_q[i]   <= z_q[i-1];
				str_q[i] <= str_q[i-1];
				end_q[i] <= end_q[i-1];
			end
			sqx_s1 <= (2*CW)'(x_q[0] * x_q[0]);
			sqy_s1 <= (2*CW)'(y_q[0] * y_q[0]);
			sum_s2 <= sqx_s1 + sqy_s1;
		end
	end

	assign rad_c[0]  = SQW'(sum_s2) << (2 * G);
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		lrie_sqrt_cell #(.RW(RW)) u_cell (
			.clk    (clk),
			.en     (en),
			.rad_i  (rad_c[k]),
			.rem_i  (rem_c[k]),
			.root_i (root_c[k]),
			.rad_q  (rad_c[k+1]),
			.rem_q  (rem_c[k+1]),
			.root_q (root_c[k+1])
		);
	end

	assign cx_c[0]  = DW'(root_c[RW]);
	assign cy_c[0]  = DW'(z_q[2+RW]) <<< G;
	assign ang_c[0] = '0;

	for (genvar j = 0; j < S; j++) begin : g_cordic
		lrie_cordic_cell #(.DW(DW), .AW(AW), .IDX(j), .FRAC(ANGLE_FRAC_BITS)) u_cell (
			.clk   (clk),
			.en    (en),
			.cx_i  (cx_c[j]),
			.cy_i  (cy_c[j]),
			.ang_i (ang_c[j]),
			.cx_q  (cx_c[j+1]),
			.cy_q  (cy_c[j+1]),
			.ang_q (ang_c[j+1])
		);
	end

	lrie_ring_map #(.AW(AW), .FRAC(ANGLE_FRAC_BITS)) u_ring (
		.clk    (clk),
		.en     (en),
		.ang    (ang_c[S]),
		.mode   (scan_mode_q),
		.res_s2 (ring_s2)
	);

	logic nz;
	assign nz = (x_q[LAT-1] != '0) || (y_q[LAT-1] != '0);

	assign res.valid         = vld_q[LAT-1];
	assign res.out_x         = x_q[LAT-1];
	assign res.out_y         = y_q[LAT-1];
	assign res.out_z         = z_q[LAT-1];
	assign res.out_strength  = str_q[LAT-1];
	assign res.out_cloud_end = end_q[LAT-1];
	assign res.kept          = nz && ring_s2.keep;
	assign res.ring_index    = (nz && ring_s2.keep) ? ring_s2.ring : 6'd0;

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.kept |-> res.ring_index == 6'd0)
		else $error("dropped point with nonzero ring");
	a_no_horiz: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.out_x == '0 && res.out_y == '0 |-> !res.kept)
		else $error("zero horizontal distance kept");
	a_bad_mode: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && scan_mode_q == MODE_UNUSED |-> !res.kept)
		else $error("unused mode kept a point");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.ring_index))
		else $error("stalled result changed");
endmodule
